### hw/rtl/rrqs_pkg.sv
// Package for the round-robin quantum scheduler.
// Holds the payload structs, register and status codes, and shared constants.
// Used by every module of the block; depends on nothing.
package rrqs_pkg;

   localparam int QUEUE_DEPTH_DEF = 128;
   localparam int TIME_W = 24;
   localparam int JOB_W = 8;
   localparam int WAIT_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TIME_W-1:0] QUANTUM_RESET = 24'd1000000;
   localparam logic [TIME_W-1:0] BUDGET_RESET = 24'd1500000;

   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_RUN = 1'b1;

   localparam logic REG_QUANTUM = 1'b0;
   localparam logic REG_BUDGET = 1'b1;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic             action;
      logic [JOB_W-1:0] job_id;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [JOB_W-1:0]  served_job;
      logic [TIME_W-1:0] slice_us;
      logic              finished;
      logic [WAIT_W-1:0] jobs_waiting;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] quantum_us;
      logic [TIME_W-1:0] job_budget_us;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [JOB_W-1:0]  job_id;
      logic [TIME_W-1:0] remaining;
   } entry_type;

endpackage

### hw/rtl/round_robin_quantum_scheduler.sv
// Top level of the round-robin quantum scheduler.
// Instantiates rrqs_csr, rrqs_ctrl and rrqs_datapath; depends on rrqs_pkg.
//
// The request channel (req_valid, req_stall, req_data) carries one item per transfer:
// an add appends req_data.job_id at the ring tail with the job budget register as its
// remaining time, and a run grants the head job a slice of at most the quantum.
// Every item yields exactly one transfer on the response channel (rsp_valid,
// rsp_stall, rsp_data) with the status, served job, slice, finished flag and the
// number of jobs left in the ring.
// An item is accepted in the idle state, which reads the ring memory at the head; in
// the finish state, once the result register is free, the commit updates that entry's
// time, writes the ring at the tail and loads the result register. No new item is
// accepted before the commit; rsp_valid is registered with the result at the commit.
// While the result register holds an unaccepted result and rsp_stall is high, the
// item in flight waits and req_stall stays high; the result holds steady.
// Synchronous reset empties the ring, zeroes the head pointer, drops rsp_valid and
// loads the quantum and budget registers with their defaults; ring entries are not
// cleared, since only written entries are ever read.
// Configuration registers sit at byte address 0 (quantum) and 4 (job budget).
module round_robin_quantum_scheduler #(
   parameter int QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rrqs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rrqs_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rrqs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rrqs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rrqs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import rrqs_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   rrqs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rrqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rrqs_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

### hw/rtl/rrqs_csr.sv
// Configuration registers of the round-robin quantum scheduler.
// An APB-style write and read port over the quantum and job budget registers.
// Depends on rrqs_pkg.
module rrqs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rrqs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rrqs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rrqs_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output rrqs_pkg::cfg_type                  cfg
);
   import rrqs_pkg::*;

   logic [TIME_W-1:0] quantum_ff, quantum_in;
   logic [TIME_W-1:0] budget_ff, budget_in;
   logic              write_en;

   assign pready = 1'b1;
   assign write_en = psel & penable & pwrite;

   always_comb begin
      quantum_in = quantum_ff;
      budget_in = budget_ff;
      if (write_en) begin
         unique case (paddr[2])
            REG_QUANTUM: quantum_in = pwdata[TIME_W-1:0];
            REG_BUDGET: budget_in = pwdata[TIME_W-1:0];
            default: quantum_in = quantum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
         budget_ff <= BUDGET_RESET;
      end else begin
         quantum_ff <= quantum_in;
         budget_ff <= budget_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_QUANTUM: prdata = CSR_DATA_W'(quantum_ff);
         REG_BUDGET: prdata = CSR_DATA_W'(budget_ff);
         default: prdata = '0;
      endcase
   end

   assign cfg.quantum_us = quantum_ff;
   assign cfg.job_budget_us = budget_ff;

endmodule

### hw/rtl/rrqs_ctrl.sv
// Controller of the round-robin quantum scheduler.
// A two-state machine that takes one item, commits it when the result register is free,
// and owns the result valid flag. Depends on rrqs_pkg.
module rrqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrqs_pkg::cmd_type cmd
);
   import rrqs_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FINISH = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd.capture = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/rrqs_datapath.sv
// Datapath of the round-robin quantum scheduler.
// Holds the job ring memory, head pointer, job count, item and result registers.
// Depends on rrqs_pkg and is driven by commands from rrqs_ctrl.
module rrqs_datapath #(
   parameter int QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rrqs_pkg::cmd_type cmd,
   input  rrqs_pkg::cfg_type cfg,
   input  rrqs_pkg::req_type req_data,
   output rrqs_pkg::rsp_type rsp_data
);
   import rrqs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
   localparam logic [CW:0] DEPTH_SUM = (CW + 1)'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

   entry_type ring_mem [QUEUE_DEPTH];

   req_type           item_ff;
   entry_type         rd_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [PW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW:0]       tail_sum;
   logic [CW:0]       tail_wrap;
   logic [PW-1:0]     tail_slot;
   logic [TIME_W-1:0] slice;
   logic [TIME_W-1:0] rem_left;
   logic              wr_en;
   entry_type         wr_data;
   logic [CW+WAIT_W-1:0] count_ext;

   assign tail_sum = {1'b0, CW'(head_ff)} + {1'b0, count_ff};
   assign tail_wrap = (tail_sum >= DEPTH_SUM) ? (tail_sum - DEPTH_SUM) : tail_sum;
   assign tail_slot = tail_wrap[PW-1:0];

   assign slice = (cfg.quantum_us < rd_ff.remaining) ? cfg.quantum_us : rd_ff.remaining;
   assign rem_left = rd_ff.remaining - slice;

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      wr_en = 1'b0;
      wr_data.job_id = item_ff.job_id;
      wr_data.remaining = cfg.job_budget_us;
      rsp_in.status = STATUS_DONE;
      rsp_in.served_job = item_ff.job_id;
      rsp_in.slice_us = '0;
      rsp_in.finished = 1'b0;
      if (cmd.commit) begin
         unique case (item_ff.action)
            ACTION_ADD: begin
               if (count_ff == DEPTH_CNT) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACTION_RUN: begin
               if (count_ff == '0) begin
                  rsp_in.status = STATUS_EMPTY;
                  rsp_in.served_job = '0;
               end else begin
                  rsp_in.served_job = rd_ff.job_id;
                  rsp_in.slice_us = slice;
                  wr_data.job_id = rd_ff.job_id;
                  wr_data.remaining = rem_left;
                  if (rem_left == '0) begin
                     rsp_in.finished = 1'b1;
                     count_in = count_ff - 1'b1;
                  end else begin
                     wr_en = 1'b1;
                  end
                  head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               end
            end
            default: rsp_in.status = STATUS_DONE;
         endcase
      end
      count_ext = {{WAIT_W{1'b0}}, count_in};
      rsp_in.jobs_waiting = count_ext[WAIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_slot] <= wr_data;
      end
      if (cmd.capture) begin
         rd_ff <= ring_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### tb/sv/round_robin_quantum_scheduler_test.sv
`timescale 1ns / 100ps
// Testbench for the round-robin quantum scheduler: directed and random add/run transfers
// with random idling on both channels, checked against an in-bench job ring predictor.
// Depends on rrqs_pkg and round_robin_quantum_scheduler.
module round_robin_quantum_scheduler_test;
   import rrqs_pkg::*;

   localparam int RING_DEPTH = QUEUE_DEPTH_DEF;
   localparam int SLOT_W = $clog2(RING_DEPTH);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   req_type     cmds_to_send[$];
   rsp_type     grants_due[$];
   int unsigned mismatch_count = 0;
   bit          req_taken = 1'b0;
   bit          calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_gap = 0;

   logic [JOB_W-1:0]  ring_id[RING_DEPTH];
   logic [TIME_W-1:0] ring_left[RING_DEPTH];
   logic [SLOT_W-1:0] head_slot = '0;
   int unsigned       jobs_held = 0;
   logic [TIME_W-1:0] quantum_now = QUANTUM_RESET;
   logic [TIME_W-1:0] budget_now = BUDGET_RESET;

   round_robin_quantum_scheduler i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
      mismatch_count++;
   endtask

   function automatic rsp_type schedule_item(input req_type item);
      rsp_type           r;
      logic [TIME_W-1:0] left;
      logic [TIME_W-1:0] grant;
      logic [SLOT_W-1:0] slot;
      r = '0;
      if (item.action == ACTION_ADD) begin
         r.served_job = item.job_id;
         if (jobs_held >= RING_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            slot = SLOT_W'(head_slot + jobs_held);
            ring_id[slot] = item.job_id;
            ring_left[slot] = budget_now;
            jobs_held++;
         end
      end else if (jobs_held == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         left = ring_left[head_slot];
         r.served_job = ring_id[head_slot];
         grant = (quantum_now < left) ? quantum_now : left;
         left = left - grant;
         r.slice_us = grant;
         if (left == 0) begin
            r.finished = 1'b1;
            jobs_held--;
         end else begin
            slot = SLOT_W'(head_slot + jobs_held);
            ring_id[slot] = r.served_job;
            ring_left[slot] = left;
         end
         head_slot = head_slot + 1'b1;
      end
      r.jobs_waiting = WAIT_W'(jobs_held);
      return r;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (cmds_to_send.size() > 0) begin
            req_data <= cmds_to_send.pop_front();
            req_valid <= 1'b1;
            if (!calm && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 18);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_gap > 0) begin
         stall_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 15) == 0) begin
            stall_gap = $urandom_range(1, 18);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               report_mismatch("unexpected transfer, status", rsp_data.status, 0);
            end else begin
               want = grants_due.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.served_job !== want.served_job)
                  report_mismatch("served_job", rsp_data.served_job, want.served_job);
               if (rsp_data.slice_us !== want.slice_us)
                  report_mismatch("slice_us", rsp_data.slice_us, want.slice_us);
               if (rsp_data.finished !== want.finished)
                  report_mismatch("finished", rsp_data.finished, want.finished);
               if (rsp_data.jobs_waiting !== want.jobs_waiting)
                  report_mismatch("jobs_waiting", rsp_data.jobs_waiting, want.jobs_waiting);
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            grants_due.push_back(schedule_item(req_data));
         end
      end
   end

   function automatic void queue_cmd(input logic action, input logic [JOB_W-1:0] id);
      req_type c;
      c.action = action;
      c.job_id = id;
      cmds_to_send.push_back(c);
   endfunction

   task automatic settle();
      while (cmds_to_send.size() != 0 || req_valid || grants_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic which, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(which) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[TIME_W-1:0] !== value[TIME_W-1:0]) begin
         report_mismatch("register readback", prdata, value[TIME_W-1:0]);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (which == REG_QUANTUM) begin
         quantum_now = value[TIME_W-1:0];
      end else begin
         budget_now = value[TIME_W-1:0];
      end
   endtask

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int unsigned       mode;
      int unsigned       add_pct;
      logic [TIME_W-1:0] q;
      logic [TIME_W-1:0] b;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_cmd(ACTION_RUN, 8'h00);
      queue_cmd(ACTION_ADD, 8'h00);
      queue_cmd(ACTION_ADD, 8'hFF);
      queue_cmd(ACTION_ADD, 8'hA5);
      queue_cmd(ACTION_ADD, 8'h5A);
      repeat (8) queue_cmd(ACTION_RUN, 8'hFF);
      queue_cmd(ACTION_RUN, 8'h33);
      settle();

      write_register(REG_QUANTUM, 32'h0000_0000);
      write_register(REG_BUDGET, 32'hFF00_0000);
      queue_cmd(ACTION_ADD, 8'h0F);
      queue_cmd(ACTION_ADD, 8'hF0);
      repeat (3) queue_cmd(ACTION_RUN, 8'h00);
      settle();

      write_register(REG_BUDGET, 32'd9);
      queue_cmd(ACTION_ADD, 8'h3C);
      repeat (2) queue_cmd(ACTION_RUN, 8'h00);
      settle();

      write_register(REG_QUANTUM, 32'h00FF_FFFF);
      write_register(REG_BUDGET, 32'hFFFF_FFFF);
      queue_cmd(ACTION_ADD, 8'hC3);
      repeat (2) queue_cmd(ACTION_RUN, 8'h00);
      settle();

      write_register(REG_QUANTUM, 32'd2);
      write_register(REG_BUDGET, 32'd5);
      repeat (RING_DEPTH - jobs_held + 2) queue_cmd(ACTION_ADD, 8'($urandom));
      repeat (4) queue_cmd(ACTION_RUN, 8'($urandom));
      queue_cmd(ACTION_ADD, 8'h81);
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         mode = $urandom_range(0, 2);
         case (mode)
            0: begin
               q = 24'($urandom_range(1, 16));
               b = 24'($urandom_range(1, 80));
            end
            1: begin
               q = 24'($urandom);
               b = 24'($urandom);
            end
            default: begin
               q = 24'($urandom_range(0, 3));
               b = 24'($urandom_range(0, 12));
            end
         endcase
         if (phase == 0) begin
            q = 24'd1;
            b = 24'd1;
         end
         write_register(REG_QUANTUM, {8'($urandom), q});
         write_register(REG_BUDGET, {8'($urandom), b});
         add_pct = (phase % 3 == 0) ? 70 : ((phase % 3 == 1) ? 50 : 35);
         if (phase == 5) begin
            calm = 1'b1;
         end
         for (int n = 0; n < 100; n++) begin
            queue_cmd(($urandom_range(0, 99) < add_pct) ? ACTION_ADD : ACTION_RUN,
                      8'($urandom));
            if (phase == 2 && n == 60) begin
               settle();
            end
         end
         settle();
      end

      repeat (RING_DEPTH + 8) queue_cmd(ACTION_RUN, 8'($urandom));
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### round_robin_quantum_scheduler.f
hw/rtl/rrqs_pkg.sv
hw/rtl/rrqs_csr.sv
hw/rtl/rrqs_ctrl.sv
hw/rtl/rrqs_datapath.sv
hw/rtl/round_robin_quantum_scheduler.sv
tb/sv/round_robin_quantum_scheduler_test.sv
